// ===== rtl/mmae_pkg.sv =====
// shared constants, types and helpers of the matrix multiply/add engine
package mmae_pkg;

    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 16;

    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;

    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 3;
    localparam int VALUE_W   = 16;
    localparam int RES_W     = 35;
    localparam int PROD_W    = 2 * ELEM_WIDTH;
    localparam int SUM_SHIFT = 8;

    localparam int IN_FIELDS_W  = 2 * POS_W + VALUE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * POS_W + RES_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_MUL    = 2'd2,
        OP_ADD    = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

    // command word from the controller to the datapath
    typedef struct packed {
        logic                  wr_a;
        logic                  wr_b;
        logic [ADDR_W-1:0]     wr_addr;
        logic [ELEM_WIDTH-1:0] wr_data;
        logic                  rd_en;
        logic [ADDR_W-1:0]     addr_a;
        logic [ADDR_W-1:0]     addr_b;
        logic                  first;
        logic                  last_k;
        logic                  is_add;
        logic [POS_W-1:0]      row;
        logic [POS_W-1:0]      col;
        logic                  last;
        logic                  err_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
        logic res_loaded;
    } t_dp_stat;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (int'(d) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage

// ===== rtl/mmae_ctrl.sv =====
// controller: input handshake, configuration registers and loop sequencer
module mmae_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_op,
    input  logic [mmae_pkg::POS_W-1:0]          i_row,
    input  logic [mmae_pkg::POS_W-1:0]          i_col,
    input  logic [mmae_pkg::VALUE_W-1:0]        i_value,
    input  logic                                i_cfg_wen,
    input  logic [mmae_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [mmae_pkg::DIM_W-1:0]          i_cfg_wdata,
    output mmae_pkg::t_dp_cmd                   o_cmd,
    input  mmae_pkg::t_dp_stat                  i_stat
);
    import mmae_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_ERR   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [DIM_W-1:0] r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic             r_is_add, n_is_add;

    logic [DIM_W-1:0] ra, ca, rb, cb, kmax;
    logic             accept, in_range, last_k, last_i, last_j, can_issue;
    t_op              op;

    assign ra = clamp_dim(r_rows_a);
    assign ca = clamp_dim(r_cols_a);
    assign rb = clamp_dim(r_rows_b);
    assign cb = clamp_dim(r_cols_b);
    assign kmax = r_is_add ? DIM_W'(1) : ca;

    assign op       = t_op'(i_op);
    // no command is taken while reset is held
    assign o_ready  = i_rst_n && (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign in_range = (int'(i_row) < MAX_DIM) && (int'(i_col) < MAX_DIM);

    assign last_k    = (DIM_W'(r_k) == kmax - DIM_W'(1));
    assign last_i    = (DIM_W'(r_i) == ra - DIM_W'(1));
    assign last_j    = (DIM_W'(r_j) == cb - DIM_W'(1));
    // the first read of an element waits for the output register to empty
    assign can_issue = (r_k != '0) || !i_stat.out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= DIM_RESET;
            r_cols_a <= DIM_RESET;
            r_rows_b <= DIM_RESET;
            r_cols_b <= DIM_RESET;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                REG_ROWS_A: r_rows_a <= i_cfg_wdata;
                REG_COLS_A: r_cols_a <= i_cfg_wdata;
                REG_ROWS_B: r_rows_b <= i_cfg_wdata;
                REG_COLS_B: r_cols_b <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_is_add <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_is_add <= n_is_add;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_is_add = r_is_add;

        o_cmd          = '0;
        o_cmd.wr_addr  = {i_row[IDX_W-1:0], i_col[IDX_W-1:0]};
        o_cmd.wr_data  = ELEM_WIDTH'(i_value);
        o_cmd.addr_a   = r_is_add ? {r_i, r_j} : {r_i, r_k};
        o_cmd.addr_b   = r_is_add ? {r_i, r_j} : {r_k, r_j};
        o_cmd.first    = (r_k == '0);
        o_cmd.last_k   = last_k;
        o_cmd.is_add   = r_is_add;
        o_cmd.row      = POS_W'(r_i);
        o_cmd.col      = POS_W'(r_j);
        o_cmd.last     = last_i && last_j;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                    case (op)
                        OP_LOAD_A: o_cmd.wr_a = in_range;
                        OP_LOAD_B: o_cmd.wr_b = in_range;
                        OP_MUL: begin
                            n_is_add = 1'b0;
                            n_state  = (ca != rb) ? S_ERR : S_ISSUE;
                        end
                        OP_ADD: begin
                            n_is_add = 1'b1;
                            n_state  = (ra != rb || ca != cb) ? S_ERR : S_ISSUE;
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE: begin
                if (can_issue) begin
                    o_cmd.rd_en = 1'b1;
                    if (last_k) begin
                        n_k     = '0;
                        n_state = S_WAIT;
                    end else begin
                        n_k = r_k + IDX_W'(1);
                    end
                end
            end
            S_WAIT: begin
                if (i_stat.res_loaded) begin
                    if (last_i && last_j) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ISSUE;
                        if (last_j) begin
                            n_j = '0;
                            n_i = r_i + IDX_W'(1);
                        end else begin
                            n_j = r_j + IDX_W'(1);
                        end
                    end
                end
            end
            S_ERR: begin
                if (!i_stat.out_valid) begin
                    o_cmd.err_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/mmae_datapath.sv =====
// datapath: element stores, multiply-accumulate pipeline and output register
module mmae_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mmae_pkg::t_dp_cmd                   i_cmd,
    output mmae_pkg::t_dp_stat                  o_stat,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [mmae_pkg::POS_W-1:0]          o_row,
    output logic [mmae_pkg::POS_W-1:0]          o_col,
    output logic [mmae_pkg::RES_W-1:0]          o_result,
    output logic                                o_last,
    output logic                                o_size_error
);
    import mmae_pkg::*;

    typedef struct packed {
        logic             first;
        logic             last_k;
        logic             is_add;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_tag;

    logic [ELEM_WIDTH-1:0] r_mem_a [MEM_DEPTH];
    logic [ELEM_WIDTH-1:0] r_mem_b [MEM_DEPTH];

    logic signed [ELEM_WIDTH-1:0] r_a_q, r_b_q;
    logic signed [RES_W-1:0]      r_term, r_acc, n_acc;
    logic                         r_v1, r_v2;
    t_tag                         r_tag1, r_tag2, tag0;

    logic signed [PROD_W-1:0]     prod;
    logic signed [ELEM_WIDTH:0]   sum;
    logic signed [RES_W-1:0]      term;

    logic                         r_out_valid;
    logic [POS_W-1:0]             r_out_row, r_out_col;
    logic [RES_W-1:0]             r_out_result;
    logic                         r_out_last, r_out_err;
    logic                         res_load;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem_a[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.wr_b) begin
            r_mem_b[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_a_q <= r_mem_a[i_cmd.addr_a];
            r_b_q <= r_mem_b[i_cmd.addr_b];
        end
    end

    assign tag0 = '{first:  i_cmd.first,  last_k: i_cmd.last_k, is_add: i_cmd.is_add,
                    row:    i_cmd.row,    col:    i_cmd.col,    last:   i_cmd.last};

    assign prod = r_a_q * r_b_q;
    assign sum  = r_a_q + r_b_q;
    // add path is q8.8 sum moved up to q16.16
    assign term = r_tag1.is_add ? (RES_W'(sum) <<< SUM_SHIFT) : RES_W'(prod);

    assign n_acc    = r_tag2.first ? r_term : r_acc + r_term;
    assign res_load = r_v2 && r_tag2.last_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_tag1 <= tag0;
        end
        if (r_v1) begin
            r_tag2 <= r_tag1;
            r_term <= term;
        end
        if (r_v2) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load || i_cmd.err_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_load) begin
            r_out_row    <= '0;
            r_out_col    <= '0;
            r_out_result <= '0;
            r_out_last   <= 1'b1;
            r_out_err    <= 1'b1;
        end else if (res_load) begin
            r_out_row    <= r_tag2.row;
            r_out_col    <= r_tag2.col;
            r_out_result <= n_acc;
            r_out_last   <= r_tag2.last;
            r_out_err    <= 1'b0;
        end
    end

    assign o_stat.out_valid  = r_out_valid;
    assign o_stat.res_loaded = res_load;

    assign o_valid      = r_out_valid;
    assign o_row        = r_out_row;
    assign o_col        = r_out_col;
    assign o_result     = r_out_result;
    assign o_last       = r_out_last;
    assign o_size_error = r_out_err;

endmodule

// ===== rtl/matrix_multiply_add_engine_unit.sv =====
// top level of the matrix multiply/add engine
// usage:
//   the slave stream carries commands: tuser holds the opcode (load a, load b,
//   multiply, add), tdata holds row, column and the q8.8 element value.
//   a load transaction writes one store element.
//   a multiply or add transaction starts a run; the block emits every result
//   element row-major on the master stream as q19.16 with tlast on the last one,
//   or a single transaction with the size error flag when dimensions disagree.
//   dimensions come from four 4-bit registers on the write port (0 reads as 1,
//   above 8 reads as 8); write them only while no run is in progress.
// sequencing:
//   each result element takes cols_a store reads (one for add), then passes
//   the operand and term registers of the shared multiply-accumulate unit,
//   and a new element starts only once the output register is empty.
//   a mismatch result goes through the error state into the output register
//   once that register is empty.
//   new commands are taken once the last result sits in the output register.
// reset clears the dimension registers to 8 and empties the output register;
// the stores are not cleared. a stalled receiver holds the result and the run.
module matrix_multiply_add_engine_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // row, col, value
    input  logic [mmae_pkg::IN_TDATA_W-1:0]        i_s_axis_tdata,
    // op
    input  logic [1:0]                             i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // out_row, out_col, result
    output logic [mmae_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                   o_m_axis_tlast,
    // size_error
    output logic                                   o_m_axis_tuser,
    input  logic                                   i_cfg_wen,
    input  logic [mmae_pkg::CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [mmae_pkg::DIM_W-1:0]             i_cfg_wdata
);
    import mmae_pkg::*;

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [POS_W-1:0] out_row, out_col;
    logic [RES_W-1:0] out_result;

    mmae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_row       (i_s_axis_tdata[POS_W-1:0]),
        .i_col       (i_s_axis_tdata[2*POS_W-1:POS_W]),
        .i_value     (i_s_axis_tdata[IN_FIELDS_W-1:2*POS_W]),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    mmae_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_row        (out_row),
        .o_col        (out_col),
        .o_result     (out_result),
        .o_last       (o_m_axis_tlast),
        .o_size_error (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_result, out_col, out_row};

endmodule

// ===== tb/sv/tb_matrix_multiply_add_engine_unit.sv =====
// self-checking testbench of the matrix multiply/add engine with directed cases and a random command stream
module tb_matrix_multiply_add_engine_unit;
    import mmae_pkg::*;

    localparam int CYCLE_LIMIT   = 3000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int ITEM_TARGET   = 270;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [RES_W-1:0] value;
        logic             last;
        logic             size_err;
    } t_result_elem;

    // mirror of both stores and the dimension registers, plus the queue of
    // result elements still owed by the block
    class t_engine_mirror;
        logic signed [ELEM_WIDTH-1:0] a_elems [MAX_DIM*MAX_DIM];
        logic signed [ELEM_WIDTH-1:0] b_elems [MAX_DIM*MAX_DIM];
        logic [DIM_W-1:0]             dims [4];
        t_result_elem                 pending_results [$];
        int errors;
        int n_checked;
        int n_size_errors;

        function new();
            dims = '{default: DIM_RESET};
            errors = 0;
            n_checked = 0;
            n_size_errors = 0;
        endfunction

        function int eff_dim(logic [DIM_W-1:0] d);
            if (d == '0) return 1;
            if (d > MAX_DIM) return MAX_DIM;
            return int'(d);
        endfunction

        function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            dims[idx] = val;
        endfunction

        function void push_elem(int r, int c, logic [RES_W-1:0] v, bit last, bit err);
            t_result_elem e;
            e.row = POS_W'(r);
            e.col = POS_W'(c);
            e.value = v;
            e.last = last;
            e.size_err = err;
            pending_results.push_back(e);
        endfunction

        // called once per accepted command transaction
        function void note_command(t_op op, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                                   logic [VALUE_W-1:0] v);
            int     ra, ca, rb, cb;
            longint acc;
            ra = eff_dim(dims[REG_ROWS_A]);
            ca = eff_dim(dims[REG_COLS_A]);
            rb = eff_dim(dims[REG_ROWS_B]);
            cb = eff_dim(dims[REG_COLS_B]);
            case (op)
                OP_LOAD_A: a_elems[r*MAX_DIM + c] = v;
                OP_LOAD_B: b_elems[r*MAX_DIM + c] = v;
                OP_MUL: begin
                    if (ca != rb) begin
                        n_size_errors++;
                        push_elem(0, 0, '0, 1'b1, 1'b1);
                    end else begin
                        for (int i = 0; i < ra; i++) begin
                            for (int j = 0; j < cb; j++) begin
                                acc = 0;
                                for (int k = 0; k < ca; k++) begin
                                    acc += longint'(a_elems[i*MAX_DIM + k]) *
                                           longint'(b_elems[k*MAX_DIM + j]);
                                end
                                push_elem(i, j, acc[RES_W-1:0],
                                          i == ra-1 && j == cb-1, 1'b0);
                            end
                        end
                    end
                end
                OP_ADD: begin
                    if (ra != rb || ca != cb) begin
                        n_size_errors++;
                        push_elem(0, 0, '0, 1'b1, 1'b1);
                    end else begin
                        for (int i = 0; i < ra; i++) begin
                            for (int j = 0; j < ca; j++) begin
                                acc = (longint'(a_elems[i*MAX_DIM + j]) +
                                       longint'(b_elems[i*MAX_DIM + j])) <<< SUM_SHIFT;
                                push_elem(i, j, acc[RES_W-1:0],
                                          i == ra-1 && j == ca-1, 1'b0);
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_element(logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                                    logic [RES_W-1:0] v, logic last, logic err);
            t_result_elem want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result: row %0d col %0d value %0d last %0b err %0b",
                         $time, r, c, $signed(v), last, err);
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (want.row !== r || want.col !== c || want.value !== v ||
                want.last !== last || want.size_err !== err) begin
                errors++;
                $display("%0t mismatch exp r%0d c%0d v%0d l%0b e%0b got r%0d c%0d v%0d l%0b e%0b",
                         $time, want.row, want.col, $signed(want.value), want.last,
                         want.size_err, r, c, $signed(v), last, err);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cmd_valid = 1'b0;
    logic [IN_TDATA_W-1:0]   cmd_data = '0;
    logic [1:0]              cmd_op = OP_LOAD_A;
    logic                    res_ready = 1'b1;
    logic                    cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_addr = REG_ROWS_A;
    logic [DIM_W-1:0]        cfg_wdata = '0;

    logic                    o_s_axis_tready;
    logic                    o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic                    o_m_axis_tlast;
    logic                    o_m_axis_tuser;

    t_engine_mirror mirror = new();

    int  cycle_count = 0;
    int  stall_mode = 0;
    int  stall_left = 0;
    int  cmds_sent = 0;
    int  runs_sent = 0;
    int  n_programs = 0;
    int  burst_left = 0;
    int  gap_max = 0;
    bit  a_written [MAX_DIM*MAX_DIM];
    bit  b_written [MAX_DIM*MAX_DIM];

    matrix_multiply_add_engine_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (cmd_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (cmd_data),
        .i_s_axis_tuser  (cmd_op),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wen       (cfg_wen),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: check accepted transactions, then choose next ready
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (rst_n && o_m_axis_tvalid && res_ready)
            mirror.check_element(o_m_axis_tdata[POS_W-1:0],
                                 o_m_axis_tdata[2*POS_W-1:POS_W],
                                 o_m_axis_tdata[2*POS_W +: RES_W], o_m_axis_tlast,
                                 o_m_axis_tuser);
        if (cycle_count % 256 == 0)
            stall_mode <= $urandom_range(0, 3);
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            res_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= ($urandom_range(0, 3) != 0);
                2: begin
                    if ($urandom_range(0, 7) == 0) begin
                        stall_left <= $urandom_range(1, 12);
                        res_ready <= 1'b0;
                    end else begin
                        res_ready <= 1'b1;
                    end
                end
                default: res_ready <= (cycle_count % 8 >= 3);
            endcase
        end
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("timeout after %0d cycles with %0d results outstanding",
                 CYCLE_LIMIT, mirror.pending_results.size());
        $display("status: fail");
        $finish;
    end

    // one command transaction; valid stays high for a following command
    task automatic issue(t_op op, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                         logic [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        cmd_valid <= 1'b1;
        cmd_data <= IN_TDATA_W'({v, c, r});
        cmd_op <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        mirror.note_command(op, r, c, v);
        burst_left--;
        cmds_sent++;
        if (op == OP_LOAD_A) a_written[r*MAX_DIM + c] = 1'b1;
        if (op == OP_LOAD_B) b_written[r*MAX_DIM + c] = 1'b1;
        if (op == OP_MUL || op == OP_ADD) runs_sent++;
    endtask

    // let the block go idle before any register write
    task automatic settle();
        cmd_valid <= 1'b0;
        burst_left = 0;
        while (mirror.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        mirror.set_dim(idx, val);
    endtask

    task automatic program_dims(logic [DIM_W-1:0] ra, logic [DIM_W-1:0] ca,
                                logic [DIM_W-1:0] rb, logic [DIM_W-1:0] cb);
        cfg_wen <= 1'b1;
        put_reg(REG_ROWS_A, ra);
        put_reg(REG_COLS_A, ca);
        put_reg(REG_ROWS_B, rb);
        put_reg(REG_COLS_B, cb);
        cfg_wen <= 1'b0;
        n_programs++;
    endtask

    // load whatever store elements the coming run reads and nobody wrote yet
    task automatic prepare_run(t_op op);
        int ra, ca, rb, cb;
        ra = mirror.eff_dim(mirror.dims[REG_ROWS_A]);
        ca = mirror.eff_dim(mirror.dims[REG_COLS_A]);
        rb = mirror.eff_dim(mirror.dims[REG_ROWS_B]);
        cb = mirror.eff_dim(mirror.dims[REG_COLS_B]);
        if (op == OP_MUL && ca == rb) begin
            for (int i = 0; i < ra; i++)
                for (int k = 0; k < ca; k++)
                    if (!a_written[i*MAX_DIM + k])
                        issue(OP_LOAD_A, POS_W'(i), POS_W'(k), VALUE_W'($urandom));
            for (int k = 0; k < ca; k++)
                for (int j = 0; j < cb; j++)
                    if (!b_written[k*MAX_DIM + j])
                        issue(OP_LOAD_B, POS_W'(k), POS_W'(j), VALUE_W'($urandom));
        end
        if (op == OP_ADD && ra == rb && ca == cb) begin
            for (int i = 0; i < ra; i++)
                for (int j = 0; j < ca; j++) begin
                    if (!a_written[i*MAX_DIM + j])
                        issue(OP_LOAD_A, POS_W'(i), POS_W'(j), VALUE_W'($urandom));
                    if (!b_written[i*MAX_DIM + j])
                        issue(OP_LOAD_B, POS_W'(i), POS_W'(j), VALUE_W'($urandom));
                end
        end
    endtask

    // mostly small dimensions, now and then the clamped extremes
    function automatic logic [DIM_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return DIM_W'($urandom_range(1, 3));
        if (roll < 85) return DIM_W'($urandom_range(4, 8));
        if (roll < 92) return '0;
        return DIM_W'($urandom_range(9, 15));
    endfunction

    // a raw register value with the same effective dimension (d itself for 2 to 7)
    function automatic logic [DIM_W-1:0] same_dim(logic [DIM_W-1:0] d);
        int e;
        e = mirror.eff_dim(d);
        if (e == 1) return DIM_W'($urandom_range(0, 1));
        if (e == MAX_DIM) return DIM_W'($urandom_range(8, 15));
        return d;
    endfunction

    task automatic random_phase();
        logic [DIM_W-1:0] ra, ca, rb, cb;
        int n_items, roll;
        t_op op;
        ra = pick_dim();
        ca = pick_dim();
        rb = pick_dim();
        cb = pick_dim();
        case ($urandom_range(0, 3))
            0: rb = same_dim(ca);
            1: begin
                rb = same_dim(ra);
                cb = same_dim(ca);
            end
            2: begin
                ca = same_dim(ra);
                rb = same_dim(ra);
                cb = same_dim(ra);
            end
            default: ;
        endcase
        program_dims(ra, ca, rb, cb);
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        n_items = $urandom_range(3, 12);
        repeat (n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                op = (roll < 22) ? OP_LOAD_A : OP_LOAD_B;
                issue(op, POS_W'($urandom), POS_W'($urandom), VALUE_W'($urandom));
            end else begin
                op = (roll < 72) ? OP_MUL : OP_ADD;
                prepare_run(op);
                issue(op, POS_W'($urandom), POS_W'($urandom), VALUE_W'($urandom));
            end
        end
        settle();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // 1x1 operands (zero register reads as one), extreme element values
        program_dims('0, '0, '0, '0);
        issue(OP_LOAD_A, 3'd0, 3'd0, 16'h7fff);
        issue(OP_LOAD_B, 3'd0, 3'd0, 16'h8000);
        issue(OP_MUL, 3'd0, 3'd0, 16'h0000);
        issue(OP_ADD, 3'd0, 3'd0, 16'h0000);
        issue(OP_LOAD_A, 3'd0, 3'd0, 16'h8000);
        issue(OP_MUL, 3'd7, 3'd7, 16'hffff);
        issue(OP_ADD, 3'd7, 3'd7, 16'hffff);
        settle();

        // inner dimensions disagree
        program_dims(4'd2, 4'd3, 4'd2, 4'd3);
        issue(OP_MUL, 3'd0, 3'd0, 16'h0000);
        settle();

        // rows agree after clamping, columns do not
        program_dims(4'd15, 4'd8, 4'd9, 4'd1);
        issue(OP_ADD, 3'd0, 3'd0, 16'h0000);
        settle();

        // longest dot product of most negative values: largest magnitude sum
        program_dims(4'd1, 4'd8, 4'd12, 4'd0);
        for (int k = 0; k < MAX_DIM; k++) begin
            issue(OP_LOAD_A, 3'd0, POS_W'(k), 16'h8000);
            issue(OP_LOAD_B, POS_W'(k), 3'd0, 16'h8000);
        end
        issue(OP_MUL, 3'd0, 3'd0, 16'h0000);
        issue(OP_ADD, 3'd0, 3'd0, 16'h0000);
        settle();

        while (cmds_sent < ITEM_TARGET)
            random_phase();
        settle();

        $display("%0d commands, %0d runs (%0d size errors), %0d result elements checked",
                 cmds_sent, runs_sent, mirror.n_size_errors, mirror.n_checked);
        $display("%0d dimension settings from 1x1 up to clamped 8x8, %0d failures",
                 n_programs, mirror.errors);
        if (mirror.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
